>>> hdl/pqpp_pkg.sv
// constants and types for the palette quantize and pixel pack unit
// no dependencies; imported by the top level and its checker
`default_nettype none

package pqpp_pkg;

  localparam int unsigned PAL_ENTRIES = 16;
  localparam int unsigned PAL_LEVELS  = 4;
  localparam int unsigned DIST_W      = 18;

  typedef logic [3:0]        pal_idx_t;
  typedef logic [1:0]        level_sel_t;
  typedef logic [DIST_W-1:0] dist_t;

  // register indexes of the configuration port
  typedef enum logic {
    CFG_FOUR_COLOUR = 1'b0,
    CFG_MASK_MODE   = 1'b1
  } cfg_index_t;

  // mask mode codes; the fourth code behaves as plain colour
  localparam logic [1:0] MASK_PLAIN = 2'd0;
  localparam logic [1:0] MASK_ALPHA = 2'd1;
  localparam logic [1:0] MASK_CLEAR = 2'd2;

  localparam logic [7:0] ALPHA_THRESHOLD = 8'd127;

  localparam pal_idx_t IDX_ZERO      = 4'd0;
  localparam pal_idx_t IDX_MASK_16   = 4'd15;
  localparam pal_idx_t IDX_MASK_4    = 4'd3;

  // the palette uses only four distinct component levels
  localparam logic [7:0] PAL_LEVEL [PAL_LEVELS] = '{8'hf7, 8'h90, 8'h06, 8'hf9};

  // level selects for each palette entry, per component
  localparam level_sel_t PAL_R_SEL [PAL_ENTRIES] = '{
    2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2,
    2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd3, 2'd0};
  localparam level_sel_t PAL_G_SEL [PAL_ENTRIES] = '{
    2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam level_sel_t PAL_B_SEL [PAL_ENTRIES] = '{
    2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0,
    2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2};

endpackage

`default_nettype wire

>>> hdl/palette_quantize_pixel_pack_unit.sv
// top level: nearest palette colour search, alpha masking and index packing
// depends on pqpp_pkg
`default_nettype none

// One RGBA pixel is accepted per cycle on the in_ stream and a packed byte
// leaves on the out_ stream every second pixel (16-colour, two nibbles, high
// first) or every fourth pixel (4-colour, split bit pairs). A pixel is held
// in the pixel register; the distance search over all palette entries, the
// mask override and the packing update are combinational into the output
// register, so out_tvalid rises when a byte's last pixel moves from the
// pixel register into the output register. Throughput is one pixel
// per cycle while out_tready is high; while a finished byte waits, the
// pixel register takes one more pixel and the input then stalls until the
// byte leaves. Configuration writes take effect at once and should be
// issued while no pixel is held in the pixel register and no byte is
// waiting in the output register.
module palette_quantize_pixel_pack_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [31:0]           in_tdata,   // red, green, blue, alpha
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // packed_byte
  input  wire logic                  cfg_we,
  input  wire pqpp_pkg::cfg_index_t  cfg_index,
  input  wire logic [1:0]            cfg_wdata
);
  import pqpp_pkg::*;

  logic        four_r;
  logic [1:0]  mask_r;

  logic        pix_valid_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;

  logic [7:0]  acc_r, acc_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  logic        advance;
  logic        emit;

  logic [15:0] sq_r [PAL_LEVELS];
  logic [15:0] sq_g [PAL_LEVELS];
  logic [15:0] sq_b [PAL_LEVELS];
  dist_t       entry_dist [PAL_ENTRIES];

  dist_t       d1 [8];
  pal_idx_t    i1 [8];
  dist_t       d2 [4];
  pal_idx_t    i2 [4];
  dist_t       d3 [2];
  pal_idx_t    i3 [2];
  pal_idx_t    nearest;
  pal_idx_t    idx;
  logic        transparent;
  logic [7:0]  base;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_r <= 1'b0;
      mask_r <= MASK_PLAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOUR_COLOUR: four_r <= cfg_wdata[0];
        CFG_MASK_MODE:   mask_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  assign advance   = pix_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !pix_valid_r || advance;

  // pixel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_tready) begin
      pix_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      red_r   <= in_tdata[7:0];
      green_r <= in_tdata[15:8];
      blue_r  <= in_tdata[23:16];
      alpha_r <= in_tdata[31:24];
    end
  end

  // squared differences against the four component levels
  always_comb begin
    logic [7:0] dr, dg, db;
    for (int l = 0; l < PAL_LEVELS; l++) begin
      dr = (red_r   >= PAL_LEVEL[l]) ? red_r   - PAL_LEVEL[l] : PAL_LEVEL[l] - red_r;
      dg = (green_r >= PAL_LEVEL[l]) ? green_r - PAL_LEVEL[l] : PAL_LEVEL[l] - green_r;
      db = (blue_r  >= PAL_LEVEL[l]) ? blue_r  - PAL_LEVEL[l] : PAL_LEVEL[l] - blue_r;
      sq_r[l] = dr * dr;
      sq_g[l] = dg * dg;
      sq_b[l] = db * db;
    end
  end

  always_comb begin
    for (int e = 0; e < PAL_ENTRIES; e++) begin
      entry_dist[e] = DIST_W'(sq_r[PAL_R_SEL[e]]) + DIST_W'(sq_g[PAL_G_SEL[e]])
                    + DIST_W'(sq_b[PAL_B_SEL[e]]);
    end
  end

  // minimum tree; the lower index keeps a tie
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (entry_dist[2*j+1] < entry_dist[2*j]) begin
        d1[j] = entry_dist[2*j+1];
        i1[j] = pal_idx_t'(2*j+1);
      end else begin
        d1[j] = entry_dist[2*j];
        i1[j] = pal_idx_t'(2*j);
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (d1[2*j+1] < d1[2*j]) begin
        d2[j] = d1[2*j+1];
        i2[j] = i1[2*j+1];
      end else begin
        d2[j] = d1[2*j];
        i2[j] = i1[2*j];
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (d2[2*j+1] < d2[2*j]) begin
        d3[j] = d2[2*j+1];
        i3[j] = i2[2*j+1];
      end else begin
        d3[j] = d2[2*j];
        i3[j] = i2[2*j];
      end
    end
    // entries 0..3 form the first second-level node
    if (four_r) begin
      nearest = i2[0];
    end else if (d3[1] < d3[0]) begin
      nearest = i3[1];
    end else begin
      nearest = i3[0];
    end
  end

  assign transparent = alpha_r < ALPHA_THRESHOLD;

  always_comb begin
    priority if (mask_r == MASK_ALPHA) begin
      idx = transparent ? (four_r ? IDX_MASK_4 : IDX_MASK_16) : IDX_ZERO;
    end else if (mask_r == MASK_CLEAR && transparent) begin
      idx = IDX_ZERO;
    end else begin
      idx = nearest;
    end
  end

  // packing
  always_comb begin
    base     = (slot_r == 2'd0) ? 8'h00 : acc_r;
    acc_nxt  = acc_r;
    slot_nxt = slot_r;
    emit     = 1'b0;
    out_data_nxt = out_data_r;
    if (four_r) begin
      acc_nxt = base | (8'(idx[0]) << (3'd7 - 3'(slot_r))) | (8'(idx[1]) << slot_r);
      if (slot_r == 2'd3) begin
        emit         = 1'b1;
        out_data_nxt = acc_nxt;
        acc_nxt      = 8'h00;
        slot_nxt     = 2'd0;
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end else begin
      if (slot_r == 2'd0) begin
        acc_nxt  = {idx, 4'h0};
        slot_nxt = 2'd1;
      end else begin
        emit         = 1'b1;
        out_data_nxt = base | {4'h0, idx};
        acc_nxt      = 8'h00;
        slot_nxt     = 2'd0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'h00;
      slot_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        acc_r  <= acc_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/pqpp_checker.sv
// port-level checks for palette_quantize_pixel_pack_unit, bound to the top level
// depends on pqpp_pkg
`default_nettype none

module pqpp_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic [31:0]          in_tdata,   // red, green, blue, alpha
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [7:0]           out_tdata,  // packed_byte
  input wire logic                 cfg_we,
  input wire pqpp_pkg::cfg_index_t cfg_index,
  input wire logic [1:0]           cfg_wdata
);
  import pqpp_pkg::*;

  logic       four_r;
  logic [1:0] mask_r;
  logic       touched_r;   // config written since the last output transaction
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_r    <= 1'b0;
      mask_r    <= MASK_PLAIN;
      touched_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        touched_r <= 1'b1;
        unique case (cfg_index)
          CFG_FOUR_COLOUR: four_r <= cfg_wdata[0];
          CFG_MASK_MODE:   mask_r <= cfg_wdata;
          default:         ;
        endcase
      end else if (out_xfer) begin
        touched_r <= 1'b0;
      end
    end
  end

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction dropped or changed");

  // a new byte needs a recent input transaction into the pixel register
  a_rise_after_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_xfer, 2))
    else $error("output appeared without a recent input transaction");

  // alpha mask mode gives only all-zero or all-one indices
  a_mask_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !touched_r && mask_r == MASK_ALPHA |->
      (four_r ? (out_tdata[0] == out_tdata[7] && out_tdata[1] == out_tdata[6] &&
                 out_tdata[2] == out_tdata[5] && out_tdata[3] == out_tdata[4])
              : ((out_tdata[3:0] == 4'h0 || out_tdata[3:0] == 4'hf) &&
                 (out_tdata[7:4] == 4'h0 || out_tdata[7:4] == 4'hf))))
    else $error("mask byte holds a colour index");

endmodule

bind palette_quantize_pixel_pack_unit pqpp_checker u_pqpp_checker (.*);

`default_nettype wire
